### design/lom_pkg.sv
// Shared types for the limit order matcher: book entry layout, controller
// states and the command and status groups between controller and datapath.
// No dependencies.
package lom_pkg;

    localparam int USER_W  = 4;
    localparam int QTY_W   = 20;
    localparam int PRICE_W = 20;
    localparam int AMT_W   = 40;

    typedef struct packed {
        logic [USER_W-1:0]  user;
        logic               side;
        logic [QTY_W-1:0]   qty;
        logic [PRICE_W-1:0] price;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    localparam logic SIDE_BUY = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_DECIDE,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_APPEND,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic scan_init;
        logic scan_step;
        logic fill;
        logic shift_rd;
        logic shift_wr;
        logic shrink;
        logic append;
        logic finish;
        logic reject;
    } cmd_t;

    typedef struct packed {
        logic qty_zero;
        logic book_full;
        logic scan_end;
        logic found;
        logic best_empties;
        logic order_empties;
        logic shift_more;
        logic out_free;
    } stat_t;

endpackage

### design/lom_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module lom_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

### design/lom_ctrl.sv
// Controller state machine of the limit order matcher.
// Depends on lom_pkg.
module lom_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  lom_pkg::stat_t stat,
    output lom_pkg::cmd_t  cmd
);
    import lom_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (stat.qty_zero)
                begin
                    state_next = ST_FINISH;
                end
                else if (stat.book_full)
                begin
                    cmd.reject = 1'b1;
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_end)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (!stat.found)
                begin
                    state_next = ST_APPEND;
                end
                else if (stat.out_free)
                begin
                    cmd.fill = 1'b1;
                    if (stat.best_empties)
                    begin
                        state_next = ST_SHIFT_RD;
                    end
                    else if (stat.order_empties)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        cmd.scan_init = 1'b1;
                        state_next    = ST_SCAN;
                    end
                end
            end
            ST_SHIFT_RD:
            begin
                if (stat.shift_more)
                begin
                    cmd.shift_rd = 1'b1;
                    state_next   = ST_SHIFT_WR;
                end
                else
                begin
                    cmd.shrink = 1'b1;
                    if (stat.qty_zero)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        cmd.scan_init = 1'b1;
                        state_next    = ST_SCAN;
                    end
                end
            end
            ST_SHIFT_WR:
            begin
                cmd.shift_wr = 1'b1;
                state_next   = ST_SHIFT_RD;
            end
            ST_APPEND:
            begin
                cmd.append = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

### design/lom_datapath.sv
// Datapath of the limit order matcher: book memory, scan compare, fill
// arithmetic, compaction, pending result and output register.
// Depends on lom_pkg and lom_ram.
module lom_datapath #(
    parameter int BOOK_SLOTS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lom_pkg::cmd_t                 cmd,
    output lom_pkg::stat_t                stat,
    input  logic [lom_pkg::USER_W-1:0]    user_id,
    input  logic                          order_side,
    input  logic [lom_pkg::QTY_W-1:0]     order_quantity,
    input  logic [lom_pkg::PRICE_W-1:0]   order_price,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [lom_pkg::USER_W-1:0]    buyer_id,
    output logic [lom_pkg::USER_W-1:0]    seller_id,
    output logic [lom_pkg::QTY_W-1:0]     fill_quantity,
    output logic [lom_pkg::PRICE_W-1:0]   fill_price,
    output logic [lom_pkg::AMT_W-1:0]     fill_amount,
    output logic [lom_pkg::QTY_W-1:0]     remaining_quantity,
    output logic                          rejected,
    output logic                          last
);
    import lom_pkg::*;

    localparam int IDX_W = $clog2(BOOK_SLOTS);
    localparam int CNT_W = $clog2(BOOK_SLOTS + 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(BOOK_SLOTS);

    // Order being worked on.
    logic [USER_W-1:0]  ord_user_reg;
    logic               ord_side_reg;
    logic [QTY_W-1:0]   ord_qty_reg;
    logic [PRICE_W-1:0] ord_price_reg;
    // Set when the order met a full book; the book may fill up later by the
    // order's own append, which must not count as a refusal.
    logic               rej_reg;

    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   scan_cnt_reg;
    logic               pipe_valid_reg;
    logic [IDX_W-1:0]   pipe_idx_reg;
    logic               found_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    entry_t             best_reg;
    logic [IDX_W-1:0]   shift_idx_reg;

    logic               pend_valid_reg;
    logic [USER_W-1:0]  pend_buyer_reg, pend_seller_reg;
    logic [QTY_W-1:0]   pend_qty_reg, pend_rem_reg;
    logic [PRICE_W-1:0] pend_price_reg;
    logic [AMT_W-1:0]   pend_amt_reg;

    logic               out_valid_reg;
    logic [USER_W-1:0]  out_buyer_reg, out_seller_reg;
    logic [QTY_W-1:0]   out_qty_reg, out_rem_reg;
    logic [PRICE_W-1:0] out_price_reg;
    logic [AMT_W-1:0]   out_amt_reg;
    logic               out_rej_reg, out_last_reg;

    entry_t             rdata;
    logic               ram_we, ram_re;
    logic [IDX_W-1:0]   ram_waddr, ram_raddr;
    entry_t             ram_wdata;

    logic               scan_rd;
    logic               crosses, better, hit;
    logic [QTY_W-1:0]   fill_q;
    logic [CNT_W-1:0]   shift_next;
    logic               out_free;

    lom_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (BOOK_SLOTS)
    ) u_book (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rdata)
    );

    assign scan_rd    = cmd.scan_step && (scan_cnt_reg < count_reg);
    assign shift_next = CNT_W'(shift_idx_reg) + CNT_W'(1);
    assign fill_q     = (ord_qty_reg < best_reg.qty) ? ord_qty_reg : best_reg.qty;
    assign out_free   = !out_valid_reg || !out_stall;

    // A resting order is a candidate when it belongs to another user, sits on
    // the other side and its price crosses the limit. Strict improvement keeps
    // the oldest order on equal prices.
    always_comb
    begin
        if (ord_side_reg == SIDE_BUY)
        begin
            crosses = rdata.price <= ord_price_reg;
            better  = rdata.price < best_reg.price;
        end
        else
        begin
            crosses = rdata.price >= ord_price_reg;
            better  = rdata.price > best_reg.price;
        end
        hit = pipe_valid_reg && (rdata.user != ord_user_reg)
              && (rdata.side != ord_side_reg) && crosses && (!found_reg || better);
    end

    always_comb
    begin
        ram_re    = scan_rd || cmd.shift_rd;
        ram_raddr = cmd.shift_rd ? shift_next[IDX_W-1:0] : scan_cnt_reg[IDX_W-1:0];
        ram_we    = cmd.fill || cmd.shift_wr || cmd.append;
        ram_waddr = best_idx_reg;
        ram_wdata = best_reg;
        if (cmd.fill)
        begin
            ram_wdata.qty = best_reg.qty - fill_q;
        end
        else if (cmd.shift_wr)
        begin
            ram_waddr = shift_idx_reg;
            ram_wdata = rdata;
        end
        else if (cmd.append)
        begin
            ram_waddr       = count_reg[IDX_W-1:0];
            ram_wdata.user  = ord_user_reg;
            ram_wdata.side  = ord_side_reg;
            ram_wdata.qty   = ord_qty_reg;
            ram_wdata.price = ord_price_reg;
        end
    end

    always_comb
    begin
        stat.qty_zero      = ord_qty_reg == '0;
        stat.book_full     = count_reg == FULL;
        stat.scan_end      = (scan_cnt_reg == count_reg) && !pipe_valid_reg;
        stat.found         = found_reg;
        stat.best_empties  = best_reg.qty <= ord_qty_reg;
        stat.order_empties = ord_qty_reg <= best_reg.qty;
        stat.shift_more    = shift_next < count_reg;
        stat.out_free      = out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ord_user_reg    <= '0;
            ord_side_reg    <= 1'b0;
            ord_qty_reg     <= '0;
            ord_price_reg   <= '0;
            rej_reg         <= 1'b0;
            count_reg       <= '0;
            scan_cnt_reg    <= '0;
            pipe_valid_reg  <= 1'b0;
            pipe_idx_reg    <= '0;
            found_reg       <= 1'b0;
            best_idx_reg    <= '0;
            best_reg        <= '0;
            shift_idx_reg   <= '0;
            pend_valid_reg  <= 1'b0;
            pend_buyer_reg  <= '0;
            pend_seller_reg <= '0;
            pend_qty_reg    <= '0;
            pend_rem_reg    <= '0;
            pend_price_reg  <= '0;
            pend_amt_reg    <= '0;
            out_valid_reg   <= 1'b0;
            out_buyer_reg   <= '0;
            out_seller_reg  <= '0;
            out_qty_reg     <= '0;
            out_rem_reg     <= '0;
            out_price_reg   <= '0;
            out_amt_reg     <= '0;
            out_rej_reg     <= 1'b0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cmd.load)
            begin
                ord_user_reg   <= user_id;
                ord_side_reg   <= order_side;
                ord_qty_reg    <= order_quantity;
                ord_price_reg  <= order_price;
                pend_valid_reg <= 1'b0;
                rej_reg        <= 1'b0;
            end
            else if (cmd.reject)
            begin
                rej_reg <= 1'b1;
            end

            if (cmd.scan_init)
            begin
                scan_cnt_reg <= '0;
                found_reg    <= 1'b0;
            end
            else if (scan_rd)
            begin
                scan_cnt_reg <= scan_cnt_reg + CNT_W'(1);
            end
            pipe_valid_reg <= scan_rd;
            pipe_idx_reg   <= scan_cnt_reg[IDX_W-1:0];

            if (hit)
            begin
                found_reg    <= 1'b1;
                best_idx_reg <= pipe_idx_reg;
                best_reg     <= rdata;
            end

            if (cmd.fill)
            begin
                // The earlier fill is now known not to be the final one.
                if (pend_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    out_buyer_reg  <= pend_buyer_reg;
                    out_seller_reg <= pend_seller_reg;
                    out_qty_reg    <= pend_qty_reg;
                    out_price_reg  <= pend_price_reg;
                    out_amt_reg    <= pend_amt_reg;
                    out_rem_reg    <= pend_rem_reg;
                    out_rej_reg    <= 1'b0;
                    out_last_reg   <= 1'b0;
                end
                pend_valid_reg  <= 1'b1;
                pend_buyer_reg  <= (ord_side_reg == SIDE_BUY) ? ord_user_reg : best_reg.user;
                pend_seller_reg <= (ord_side_reg == SIDE_BUY) ? best_reg.user : ord_user_reg;
                pend_qty_reg    <= fill_q;
                pend_price_reg  <= best_reg.price;
                pend_amt_reg    <= AMT_W'(fill_q) * AMT_W'(best_reg.price);
                pend_rem_reg    <= ord_qty_reg - fill_q;
                ord_qty_reg     <= ord_qty_reg - fill_q;
                best_reg.qty    <= best_reg.qty - fill_q;
                shift_idx_reg   <= best_idx_reg;
            end

            if (cmd.shift_wr)
            begin
                shift_idx_reg <= shift_next[IDX_W-1:0];
            end

            if (cmd.shrink)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
            else if (cmd.append)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end

            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
                out_last_reg  <= 1'b1;
                out_rej_reg   <= rej_reg;
                if (pend_valid_reg)
                begin
                    out_buyer_reg  <= pend_buyer_reg;
                    out_seller_reg <= pend_seller_reg;
                    out_qty_reg    <= pend_qty_reg;
                    out_price_reg  <= pend_price_reg;
                    out_amt_reg    <= pend_amt_reg;
                    out_rem_reg    <= pend_rem_reg;
                end
                else
                begin
                    out_buyer_reg  <= '0;
                    out_seller_reg <= '0;
                    out_qty_reg    <= '0;
                    out_price_reg  <= '0;
                    out_amt_reg    <= '0;
                    out_rem_reg    <= ord_qty_reg;
                end
                pend_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid          = out_valid_reg;
    assign buyer_id           = out_buyer_reg;
    assign seller_id          = out_seller_reg;
    assign fill_quantity      = out_qty_reg;
    assign fill_price         = out_price_reg;
    assign fill_amount        = out_amt_reg;
    assign remaining_quantity = out_rem_reg;
    assign rejected           = out_rej_reg;
    assign last               = out_last_reg;
endmodule

### design/limit_order_matcher_top.sv
// Top level of the limit order matcher: price-time priority order book.
// Depends on lom_pkg, lom_ctrl, lom_datapath and lom_ram.
//
// Usage:
// The input channel (in_valid/in_stall) takes one new limit order per beat.
// The output channel (out_valid/out_stall) gives one beat per fill, or one
// beat when the order did not fill; last marks the final beat of an order.
// A zero quantity order gives a single all-zero beat with last set, and an
// order that meets a full book gives a single beat with rejected set.
// Orders are worked one at a time: in_stall stays high from acceptance until
// the final beat of that order is loaded into the output register.
// Each fill is preceded by a scan of the book memory, one entry per cycle.
// A resting order that is used up is squeezed out by copying the younger
// entries down, with a read and then a write for each entry.
// A fill beat is held back until the next fill or the end of the order is
// known, so the first beat of an order leaves after its second fill or end.
// When out_stall is high the output register holds its beat and the
// controller waits before loading the next one; no beat is lost.
// Reset empties the book at once (the count clears) and drops any beat.
module limit_order_matcher_top #(
    parameter int BOOK_SLOTS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [lom_pkg::USER_W-1:0]    user_id,
    input  logic                          order_side,
    input  logic [lom_pkg::QTY_W-1:0]     order_quantity,
    input  logic [lom_pkg::PRICE_W-1:0]   order_price,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [lom_pkg::USER_W-1:0]    buyer_id,
    output logic [lom_pkg::USER_W-1:0]    seller_id,
    output logic [lom_pkg::QTY_W-1:0]     fill_quantity,
    output logic [lom_pkg::PRICE_W-1:0]   fill_price,
    output logic [lom_pkg::AMT_W-1:0]     fill_amount,
    output logic [lom_pkg::QTY_W-1:0]     remaining_quantity,
    output logic                          rejected,
    output logic                          last
);
    import lom_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // The controller sequences check, scan, fill, compaction and append.
    lom_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath owns the book memory and all order and result registers.
    lom_datapath #(
        .BOOK_SLOTS (BOOK_SLOTS)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .stat               (stat),
        .user_id            (user_id),
        .order_side         (order_side),
        .order_quantity     (order_quantity),
        .order_price        (order_price),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .buyer_id           (buyer_id),
        .seller_id          (seller_id),
        .fill_quantity      (fill_quantity),
        .fill_price         (fill_price),
        .fill_amount        (fill_amount),
        .remaining_quantity (remaining_quantity),
        .rejected           (rejected),
        .last               (last)
    );

`ifndef NO_ASSERTIONS
    // A refused order never reports a fill and always closes the order.
    a_reject_closes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rejected |-> last && fill_quantity == '0)
        else $error("rejected beat carries a fill or is not last");

    // A beat without a fill is always the only and final beat of its order.
    a_nofill_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fill_quantity == '0 |-> last)
        else $error("beat without fill is not last");

    // Once an order is taken the block works on it and takes no other.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted twice in a row");
`endif
endmodule

### tb/testbench.sv
// Self-checking testbench for limit_order_matcher_top: drives limit orders,
// predicts every fill from its own book copy and compares each output beat.
// Depends on lom_pkg and the limit_order_matcher_top RTL.
module testbench;
    import lom_pkg::*;

    localparam int SLOTS = 64;
    localparam int ORDER_TARGET = 430;

    typedef struct packed {
        logic [USER_W-1:0]  user;
        logic               side;
        logic [QTY_W-1:0]   qty;
        logic [PRICE_W-1:0] price;
    } order_t;

    typedef struct packed {
        logic [USER_W-1:0]  buyer;
        logic [USER_W-1:0]  seller;
        logic [QTY_W-1:0]   qty;
        logic [PRICE_W-1:0] price;
        logic [AMT_W-1:0]   amount;
        logic [QTY_W-1:0]   remain;
        logic               rej;
        logic               fin;
    } fill_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [USER_W-1:0] user_id;
    logic order_side;
    logic [QTY_W-1:0] order_quantity;
    logic [PRICE_W-1:0] order_price;
    logic out_valid;
    logic out_stall;
    logic [USER_W-1:0] buyer_id;
    logic [USER_W-1:0] seller_id;
    logic [QTY_W-1:0] fill_quantity;
    logic [PRICE_W-1:0] fill_price;
    logic [AMT_W-1:0] fill_amount;
    logic [QTY_W-1:0] remaining_quantity;
    logic rejected;
    logic last;

    // Orders waiting to be driven, and the fills the book model expects.
    order_t pending_orders[$];
    fill_t  expected_fills[$];
    // The book model: resting orders, oldest first.
    order_t resting[$];

    int mismatches = 0;
    int orders_sent = 0;
    bit stimulus_done = 0;
    bit quiet_phase = 0;
    // High for the cycle after an input beat was taken at the rising edge.
    bit in_taken = 0;
    int in_gap = 0;
    int out_gap = 0;

    limit_order_matcher_top #(.BOOK_SLOTS(SLOTS)) dut (.*);

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Build one result beat; amount follows from quantity and price.
    function automatic fill_t make_fill(logic [USER_W-1:0] b, logic [USER_W-1:0] s,
                                        logic [QTY_W-1:0] q, logic [PRICE_W-1:0] p,
                                        logic [QTY_W-1:0] rem, logic rj, logic f);
        fill_t r;
        r.buyer = b;
        r.seller = s;
        r.qty = q;
        r.price = p;
        r.amount = AMT_W'(q) * AMT_W'(p);
        r.remain = rem;
        r.rej = rj;
        r.fin = f;
        return r;
    endfunction

    // Price-time matching on the book model. Appends the fills that the
    // order causes to expected_fills, with last set on the final one.
    task automatic match_order(input order_t o);
        logic [QTY_W-1:0] open_qty;
        logic [QTY_W-1:0] traded;
        int best;
        int fills;
        fill_t f;
        open_qty = o.qty;
        fills = 0;
        if (open_qty == '0) begin
            expected_fills.insert(expected_fills.size(),
                                  make_fill('0, '0, '0, '0, '0, 1'b0, 1'b1));
            return;
        end
        if (resting.size() >= SLOTS) begin
            expected_fills.insert(expected_fills.size(),
                                  make_fill('0, '0, '0, '0, open_qty, 1'b1, 1'b1));
            return;
        end
        while (open_qty != '0) begin
            best = -1;
            for (int i = 0; i < resting.size(); i++) begin
                if (resting[i].user == o.user || resting[i].side == o.side)
                    continue;
                if (o.side == SIDE_BUY) begin
                    if (resting[i].price > o.price)
                        continue;
                    if (best < 0 || resting[i].price < resting[best].price)
                        best = i;
                end else begin
                    if (resting[i].price < o.price)
                        continue;
                    if (best < 0 || resting[i].price > resting[best].price)
                        best = i;
                end
            end
            if (best < 0)
                break;
            traded = (open_qty < resting[best].qty) ? open_qty : resting[best].qty;
            open_qty -= traded;
            resting[best].qty -= traded;
            if (o.side == SIDE_BUY)
                f = make_fill(o.user, resting[best].user, traded, resting[best].price,
                              open_qty, 1'b0, 1'b0);
            else
                f = make_fill(resting[best].user, o.user, traded, resting[best].price,
                              open_qty, 1'b0, 1'b0);
            expected_fills.insert(expected_fills.size(), f);
            fills++;
            if (resting[best].qty == '0)
                resting.delete(best);
        end
        if (open_qty != '0 && resting.size() < SLOTS) begin
            o.qty = open_qty;
            resting.insert(resting.size(), o);
        end
        if (fills == 0)
            expected_fills.insert(expected_fills.size(),
                                  make_fill('0, '0, '0, '0, open_qty, 1'b0, 1'b1));
        else
            expected_fills[$].fin = 1'b1;
    endtask

    function automatic order_t mk(int u, int s, int q, int p);
        order_t o;
        o.user = USER_W'(u);
        o.side = 1'(s);
        o.qty = QTY_W'(q);
        o.price = PRICE_W'(p);
        return o;
    endfunction

    // Random order. Prices sit in a narrow band most of the time so that
    // books cross often; quantities are mostly small so orders rest and fill.
    function automatic order_t random_order();
        order_t o;
        int pick;
        o.user = USER_W'($urandom_range(0, 15));
        o.side = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 4)
            o.qty = '0;
        else if (pick < 10)
            o.qty = QTY_W'($urandom);
        else
            o.qty = QTY_W'($urandom_range(1, 40));
        pick = $urandom_range(0, 99);
        if (pick < 8)
            o.price = PRICE_W'($urandom);
        else
            o.price = PRICE_W'(1000 + $urandom_range(0, 20));
        return o;
    endfunction

    initial
    begin
        // Directed part: extremes of every field, no-fill, zero quantity,
        // own-order skip, best price and oldest-first ties, partial fills.
        pending_orders.insert(pending_orders.size(), mk(0, 0, 0, 0));
        pending_orders.insert(pending_orders.size(), mk(15, 1, 20'hFFFFF, 20'hFFFFF));
        pending_orders.insert(pending_orders.size(), mk(15, 0, 5, 20'hFFFFF));
        pending_orders.insert(pending_orders.size(), mk(0, 0, 20'hFFFFF, 20'hFFFFF));
        pending_orders.insert(pending_orders.size(), mk(3, 1, 10, 500));
        pending_orders.insert(pending_orders.size(), mk(4, 1, 10, 400));
        pending_orders.insert(pending_orders.size(), mk(5, 1, 10, 400));
        pending_orders.insert(pending_orders.size(), mk(3, 0, 50, 600));
        pending_orders.insert(pending_orders.size(), mk(6, 0, 25, 600));
        pending_orders.insert(pending_orders.size(), mk(7, 0, 10, 100));
        pending_orders.insert(pending_orders.size(), mk(8, 0, 10, 200));
        pending_orders.insert(pending_orders.size(), mk(9, 1, 15, 0));
        pending_orders.insert(pending_orders.size(), mk(10, 1, 0, 20'hFFFFF));
        pending_orders.insert(pending_orders.size(), mk(10, 1, 20'hAAAAA, 20'h55555));
        pending_orders.insert(pending_orders.size(), mk(5, 0, 20'h55555, 20'hAAAAA));
        // Fill the book with non-crossing buys so the full-book rejection
        // and the zero-quantity drop on a full book both show up.
        for (int i = 0; i < SLOTS + 1; i++)
            pending_orders.insert(pending_orders.size(), mk(i % 16, 0, 1, 1));
        pending_orders.insert(pending_orders.size(), mk(2, 1, 0, 1));
        pending_orders.insert(pending_orders.size(), mk(2, 0, 7, 1));
        // A large sell drains the book in many fills, up to the maximum.
        pending_orders.insert(pending_orders.size(), mk(1, 1, 20'hFFFFF, 0));
        pending_orders.insert(pending_orders.size(), mk(2, 1, 20'hFFFFF, 0));
        while (pending_orders.size() < ORDER_TARGET)
            pending_orders.insert(pending_orders.size(), random_order());
    end

    // Driver: new beat on the falling edge, valid held while stalled.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            user_id <= '0;
            order_side <= 1'b0;
            order_quantity <= '0;
            order_price <= '0;
            out_stall <= 1'b0;
        end else begin
            if (!in_valid || in_taken) begin
                if (in_gap > 0) begin
                    in_gap <= in_gap - 1;
                    in_valid <= 1'b0;
                end else if (pending_orders.size() > 0 &&
                             (quiet_phase || $urandom_range(0, 9) != 0)) begin
                    order_t o;
                    o = pending_orders.pop_front();
                    in_valid <= 1'b1;
                    user_id <= o.user;
                    order_side <= o.side;
                    order_quantity <= o.qty;
                    order_price <= o.price;
                end else begin
                    in_valid <= 1'b0;
                    if (!quiet_phase && pending_orders.size() > 0)
                        in_gap <= $urandom_range(0, 5);
                end
            end
            // Receiver stalls in bursts of random length.
            if (out_gap > 0) begin
                out_gap <= out_gap - 1;
                out_stall <= 1'b1;
            end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
                out_gap <= $urandom_range(0, 5);
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Monitor: accepted orders feed the book model, accepted beats are
    // compared against the oldest expected fill.
    always @(posedge clk)
    begin
        if (!rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= in_valid && !in_stall;
            if (in_valid && !in_stall) begin
                match_order(mk(user_id, order_side, order_quantity, order_price));
                orders_sent++;
                if (orders_sent > 300)
                    quiet_phase <= 1'b1;
            end
            if (out_valid && !out_stall) begin
                fill_t got;
                fill_t want;
                got = make_fill(buyer_id, seller_id, fill_quantity, fill_price,
                                remaining_quantity, rejected, last);
                got.amount = fill_amount;
                if (expected_fills.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected beat: %p", got);
                end else begin
                    want = expected_fills.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("beat mismatch: expected %p actual %p", want, got);
                    end
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        user_id = '0;
        order_side = 1'b0;
        order_quantity = '0;
        order_price = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        // Wait until every order has been taken and every beat returned.
        wait (pending_orders.size() == 0 && !in_valid && !in_stall);
        wait (expected_fills.size() == 0);
        repeat (200) @(posedge clk);
        if (mismatches == 0 && expected_fills.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    // Generous limit for an order that fills against the whole book under heavy stalls.
    initial
    begin
        #300000000;
        $display("testbench: FAIL");
        $finish;
    end
endmodule
